// ----- hdl/smme_pkg.sv -----
`default_nettype none

package smme_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int BIN_IDX_BITS  = 9;
   localparam int COEFF_BITS    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic CSR_IDX_SMOOTH_COEFF  = 1'b0;
   localparam logic CSR_IDX_DEFAULT_VALUE = 1'b1;

   typedef struct packed {
      logic                          cmd;
      logic [BIN_IDX_BITS-1:0]       bin_index;
      logic signed [SAMPLE_BITS-1:0] sample_value;
   } req_type;

   typedef struct packed {
      logic [BIN_IDX_BITS-1:0]       bin_out;
      logic signed [SAMPLE_BITS-1:0] min_value;
      logic signed [SAMPLE_BITS-1:0] max_value;
      logic signed [SAMPLE_BITS-1:0] avg_value;
   } rsp_type;

   typedef struct packed {
      logic [COEFF_BITS-1:0]         smooth_coeff;
      logic signed [SAMPLE_BITS-1:0] default_value;
   } cfg_type;

   typedef struct packed {
      logic                          valid;
      logic signed [SAMPLE_BITS-1:0] min_value;
      logic signed [SAMPLE_BITS-1:0] max_value;
   } entry_type;

endpackage

`default_nettype wire

// ----- hdl/smoothed_min_max_envelope.sv -----
// An add on a bin in range passes through the read, multiply and write-back steps before
// its result strobe, and busy holds off a new item until the last one is written back.
// A clear or an out-of-range bin gives its strobe in the next cycle; a clear then keeps
// busy high while the store is swept one entry per cycle.
// Reset is synchronous and starts the same sweep; registers are writable meanwhile.
// The receiver cannot stall: each result beat is shown for one cycle only.
`default_nettype none

module smoothed_min_max_envelope #(
   parameter int BINS = 512
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire smme_pkg::req_type                     req_payload,
   output logic                                       rsp_strobe,
   output smme_pkg::rsp_type                          rsp_payload,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [smme_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [smme_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [smme_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                       pready
);

   localparam int AW = $clog2(BINS);
   localparam int SB = smme_pkg::SAMPLE_BITS;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_WB
   } state_type;

   state_type           state_ff;
   logic [AW-1:0]       clr_cnt_ff;
   smme_pkg::req_type   item_ff;
   logic                rsp_strobe_ff;
   smme_pkg::rsp_type   rsp_ff;

   smme_pkg::cfg_type   cfg;
   smme_pkg::entry_type rd_data;
   smme_pkg::entry_type wr_data;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;
   logic                in_range;
   logic signed [SB-1:0] old_min;
   logic signed [SB-1:0] old_max;
   logic signed [SB-1:0] new_min;
   logic signed [SB-1:0] new_max;
   logic signed [SB:0]   avg_sum;

   smme_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   smme_store #(
      .BINS (BINS),
      .AW   (AW)
   ) u_store (
      .clock   (clock),
      .rd_addr (AW'(req_payload.bin_index)),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign old_min = rd_data.valid ? rd_data.min_value : cfg.default_value;
   assign old_max = rd_data.valid ? rd_data.max_value : cfg.default_value;

   smme_blend u_blend_min (
      .clock  (clock),
      .load   (state_ff == ST_MUL),
      .update (item_ff.sample_value < old_min),
      .sample (item_ff.sample_value),
      .old    (old_min),
      .coeff  (cfg.smooth_coeff),
      .result (new_min)
   );

   smme_blend u_blend_max (
      .clock  (clock),
      .load   (state_ff == ST_MUL),
      .update (item_ff.sample_value > old_max),
      .sample (item_ff.sample_value),
      .old    (old_max),
      .coeff  (cfg.smooth_coeff),
      .result (new_max)
   );

   assign in_range = 32'(req_payload.bin_index) < BINS;
   assign avg_sum  = (SB + 1)'(new_min) + (SB + 1)'(new_max);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_WB: begin
            wr_en             = 1'b1;
            wr_addr           = AW'(item_ff.bin_index);
            wr_data.valid     = 1'b1;
            wr_data.min_value = new_min;
            wr_data.max_value = new_max;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(BINS - 1)) begin
                  clr_cnt_ff <= '0;
                  state_ff   <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  item_ff           <= req_payload;
                  rsp_ff.bin_out    <= req_payload.bin_index;
                  rsp_ff.min_value  <= cfg.default_value;
                  rsp_ff.max_value  <= cfg.default_value;
                  rsp_ff.avg_value  <= cfg.default_value;
                  if (req_payload.cmd == smme_pkg::CMD_CLEAR) begin
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_CLEAR;
                  end else if (!in_range) begin
                     rsp_strobe_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               state_ff <= ST_WB;
            end
            ST_WB: begin
               rsp_ff.bin_out   <= item_ff.bin_index;
               rsp_ff.min_value <= new_min;
               rsp_ff.max_value <= new_max;
               rsp_ff.avg_value <= avg_sum[SB:1];
               rsp_strobe_ff    <= 1'b1;
               state_ff         <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy        = state_ff != ST_IDLE;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- hdl/smme_csr.sv -----
`default_nettype none

module smme_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [smme_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [smme_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [smme_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                      pready,
   output smme_pkg::cfg_type                         cfg
);

   smme_pkg::cfg_type cfg_ff;
   logic              csr_index;
   logic              wr_beat;

   assign csr_index = paddr[2];
   assign wr_beat   = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_beat) begin
         case (csr_index)
            smme_pkg::CSR_IDX_SMOOTH_COEFF: begin
               cfg_ff.smooth_coeff <= pwdata[smme_pkg::COEFF_BITS-1:0];
            end
            smme_pkg::CSR_IDX_DEFAULT_VALUE: begin
               cfg_ff.default_value <= pwdata[smme_pkg::SAMPLE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         smme_pkg::CSR_IDX_SMOOTH_COEFF: begin
            prdata = smme_pkg::CSR_DATA_BITS'(cfg_ff.smooth_coeff);
         end
         smme_pkg::CSR_IDX_DEFAULT_VALUE: begin
            prdata = smme_pkg::CSR_DATA_BITS'(unsigned'(cfg_ff.default_value));
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/smme_store.sv -----
`default_nettype none

module smme_store #(
   parameter int BINS = 512,
   parameter int AW   = $clog2(BINS)
) (
   input  wire logic                 clock,
   input  wire logic [AW-1:0]        rd_addr,
   output smme_pkg::entry_type       rd_data,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire smme_pkg::entry_type  wr_data
);

   smme_pkg::entry_type mem [BINS];
   smme_pkg::entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hdl/smme_blend.sv -----
`default_nettype none

module smme_blend (
   input  wire logic                                    clock,
   input  wire logic                                    load,
   input  wire logic                                    update,
   input  wire logic signed [smme_pkg::SAMPLE_BITS-1:0] sample,
   input  wire logic signed [smme_pkg::SAMPLE_BITS-1:0] old,
   input  wire logic        [smme_pkg::COEFF_BITS-1:0]  coeff,
   output logic signed      [smme_pkg::SAMPLE_BITS-1:0] result
);

   localparam int DW = smme_pkg::SAMPLE_BITS + 1;
   localparam int CW = smme_pkg::COEFF_BITS + 1;
   localparam int PW = DW + CW;
   localparam int SW = PW - smme_pkg::COEFF_BITS + 1;

   // The blend equals sample + floor((old - sample) * c / 2^16).
   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic                 update_ff;
   logic signed [smme_pkg::SAMPLE_BITS-1:0] old_ff;
   logic signed [smme_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic signed [SW-1:0] sum;

   assign diff    = DW'(old) - DW'(sample);
   assign prod_in = PW'(diff) * PW'(signed'({1'b0, coeff}));

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff   <= prod_in;
         update_ff <= update;
         old_ff    <= old;
         sample_ff <= sample;
      end
   end

   assign sum    = SW'(sample_ff) + SW'(prod_ff >>> smme_pkg::COEFF_BITS);
   assign result = update_ff ? sum[smme_pkg::SAMPLE_BITS-1:0] : old_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_smoothed_min_max_envelope.sv -----
`timescale 1ns / 100ps

module tb_smoothed_min_max_envelope;

   localparam int ENV_BINS = 512;
   localparam int RANDOM_PER_PHASE = 256;
   localparam int WATCHDOG_CYCLES = 5000;
   localparam int SB = smme_pkg::SAMPLE_BITS;
   localparam int CB = smme_pkg::COEFF_BITS;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   smme_pkg::req_type req_payload = '0;
   logic rsp_strobe;
   smme_pkg::rsp_type rsp_payload;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [smme_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [smme_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [smme_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   smme_pkg::req_type pending_requests[$];
   smme_pkg::rsp_type expected_envelopes[$];
   int send_gap_pct = 14;
   int mismatches = 0;
   int n_accepted = 0;
   int n_clears = 0;
   int n_checked = 0;
   int n_settings = 0;
   int idle_cycles = 0;

   logic signed [SB-1:0] env_lo[ENV_BINS];
   logic signed [SB-1:0] env_hi[ENV_BINS];
   bit env_live[ENV_BINS];
   logic [CB-1:0] cur_coeff = '0;
   logic signed [SB-1:0] cur_default = '0;

   smoothed_min_max_envelope #(.BINS(ENV_BINS)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The blended extreme is rounded toward minus infinity.
   function automatic logic signed [SB-1:0] blend_toward(longint s, longint old);
      longint acc;
      acc = s * (65536 - longint'(cur_coeff)) + old * longint'(cur_coeff);
      return SB'(acc >>> 16);
   endfunction

   function automatic smme_pkg::rsp_type predict_envelope(smme_pkg::req_type r);
      smme_pkg::rsp_type o;
      longint s;
      longint lo;
      longint hi;
      s = longint'(r.sample_value);
      lo = longint'(cur_default);
      hi = longint'(cur_default);
      if (r.cmd == smme_pkg::CMD_CLEAR) begin
         foreach (env_live[i]) env_live[i] = 1'b0;
      end else if (r.bin_index < ENV_BINS) begin
         if (env_live[r.bin_index]) begin
            lo = longint'(env_lo[r.bin_index]);
            hi = longint'(env_hi[r.bin_index]);
         end
         if (s < lo) lo = longint'(blend_toward(s, lo));
         if (s > hi) hi = longint'(blend_toward(s, hi));
         env_lo[r.bin_index] = SB'(lo);
         env_hi[r.bin_index] = SB'(hi);
         env_live[r.bin_index] = 1'b1;
      end
      o.bin_out = r.bin_index;
      o.min_value = SB'(lo);
      o.max_value = SB'(hi);
      o.avg_value = SB'((lo + hi) >>> 1);
      return o;
   endfunction

   function automatic smme_pkg::req_type random_request();
      smme_pkg::req_type r;
      r.cmd = ($urandom_range(99) == 0) ? smme_pkg::CMD_CLEAR : smme_pkg::CMD_ADD;
      if ($urandom_range(99) < 70) begin
         r.bin_index = $urandom_range(1) ? 9'($urandom_range(3)) : 9'(511 - $urandom_range(3));
      end else begin
         r.bin_index = 9'($urandom);
      end
      case ($urandom_range(3))
         0, 1: r.sample_value = 24'($urandom);
         2: r.sample_value = 24'($urandom_range(512)) - 24'd256;
         default: r.sample_value = $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(3))
                                                     : 24'h800000 + 24'($urandom_range(3));
      endcase
      return r;
   endfunction

   task automatic queue_request(logic cmd, int bin, int sample);
      smme_pkg::req_type r;
      r.cmd = cmd;
      r.bin_index = 9'(bin);
      r.sample_value = 24'(sample);
      pending_requests.push_back(r);
   endtask

   task automatic check_field(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // Write one register, then read it back over the same port.
   task automatic write_csr(logic idx, logic [31:0] value, logic [31:0] mask);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (((prdata ^ value) & mask) != 0) begin
         $error("register %0d readback: expected %0d, got %0d", idx, value & mask, prdata & mask);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(logic [CB-1:0] coeff, logic signed [SB-1:0] dflt);
      write_csr(smme_pkg::CSR_IDX_SMOOTH_COEFF, {16'd0, coeff}, 32'h0000FFFF);
      write_csr(smme_pkg::CSR_IDX_DEFAULT_VALUE, {{8{dflt[SB-1]}}, dflt}, 32'h00FFFFFF);
      cur_coeff = coeff;
      cur_default = dflt;
      n_settings++;
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || start || expected_envelopes.size() != 0 || busy);
      repeat (4) @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_requests
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            expected_envelopes.push_back(predict_envelope(req_payload));
            n_accepted++;
            if (req_payload.cmd == smme_pkg::CMD_CLEAR) n_clears++;
            next_start = 1'b0;
         end
         if (!next_start && pending_requests.size() != 0
             && $urandom_range(99) >= send_gap_pct) begin
            req_payload <= pending_requests.pop_front();
            next_start = 1'b1;
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin : check_results
      smme_pkg::rsp_type want_env;
      if (!reset && rsp_strobe) begin
         if (expected_envelopes.size() == 0) begin
            $error("result beat for bin %0d with nothing outstanding", rsp_payload.bin_out);
            mismatches++;
         end else begin
            want_env = expected_envelopes.pop_front();
            check_field("bin_out", 32'(want_env.bin_out), 32'(rsp_payload.bin_out));
            check_field("min_value", 32'(want_env.min_value), 32'(rsp_payload.min_value));
            check_field("max_value", 32'(want_env.max_value), 32'(rsp_payload.max_value));
            check_field("avg_value", 32'(want_env.avg_value), 32'(rsp_payload.avg_value));
            n_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("watchdog: no beat moved for %0d cycles", idle_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_phases
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait_until_drained();

      set_config(16'd0, 24'sd0);
      queue_request(smme_pkg::CMD_ADD, 0, 8388607);
      queue_request(smme_pkg::CMD_ADD, 0, -8388608);
      queue_request(smme_pkg::CMD_ADD, 0, 0);
      queue_request(smme_pkg::CMD_ADD, 511, 5);
      queue_request(smme_pkg::CMD_ADD, 511, -5);
      queue_request(smme_pkg::CMD_ADD, 300, 0);
      queue_request(smme_pkg::CMD_CLEAR, 7, -1);
      queue_request(smme_pkg::CMD_ADD, 0, 1);
      wait_until_drained();

      set_config(16'hFFFF, 24'sh800000);
      queue_request(smme_pkg::CMD_ADD, 0, 8388607);
      queue_request(smme_pkg::CMD_ADD, 0, -8388608);
      queue_request(smme_pkg::CMD_ADD, 0, 8388607);
      queue_request(smme_pkg::CMD_ADD, 1, -1);
      queue_request(smme_pkg::CMD_CLEAR, 511, -1);
      queue_request(smme_pkg::CMD_ADD, 511, -8388608);
      wait_until_drained();

      set_config(16'h8000, 24'sd8388607);
      queue_request(smme_pkg::CMD_ADD, 5, -8388608);
      queue_request(smme_pkg::CMD_ADD, 5, 8388607);
      queue_request(smme_pkg::CMD_ADD, 5, 0);
      queue_request(smme_pkg::CMD_ADD, 5, -3);
      queue_request(smme_pkg::CMD_ADD, 5, 3);

      // Each phase starts only once every outstanding result has come back.
      for (int k = 0; k < 6; k++) begin
         wait_until_drained();
         set_config((k == 0) ? 16'hFFFF : (k == 3) ? 16'd0 : 16'($urandom),
                    (k == 1) ? 24'sh800000 : (k == 4) ? 24'sd8388607 : 24'($urandom));
         send_gap_pct = (k < 2) ? 14 : (k < 4) ? 70 : 0;
         repeat (RANDOM_PER_PHASE) pending_requests.push_back(random_request());
      end
      wait_until_drained();

      $display("%0d request beats (%0d clears) over %0d register settings, %0d results checked",
               n_accepted, n_clears, n_settings, n_checked);
      if (mismatches == 0 && expected_envelopes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
